### hw/rtl/sabs_pkg.sv
// ----------------------------------------------------------------------------
// sabs_pkg: shared types and constants for the sorted array binary search
// Holds the opcode and status codes, the stream widths and the index type
// that the search sequencer and its compare unit both use.
// ----------------------------------------------------------------------------
package sabs_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 32;

  // Field widths of the stream payloads.
  localparam int IDX_BITS    = 10;
  localparam int FIELD_BITS  = 32;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 16;

  // Search bounds are signed so that high may step to -1 and low to 1024.
  localparam int BOUND_W = IDX_BITS + 2;
  typedef logic signed [BOUND_W-1:0] bound_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_RANGE = 2'd2
  } status_t;

  // Outcome of one probe compare.
  typedef struct packed {
    logic hit;
    logic greater;
  } cmp_res_t;

endpackage

### hw/rtl/sabs_step.sv
// ----------------------------------------------------------------------------
// sabs_step: probe compare and range narrowing
// Compares one array entry against the key and forms the next search bounds
// from the probed midpoint.
// ----------------------------------------------------------------------------
module sabs_step #(
  parameter int VALUE_BITS = sabs_pkg::VALUE_BITS_DEF
) (
  input  logic signed [VALUE_BITS-1:0] entry_i,
  input  logic signed [VALUE_BITS-1:0] key_i,
  input  logic [sabs_pkg::IDX_BITS-1:0] mid_i,
  input  sabs_pkg::bound_t              low_i,
  input  sabs_pkg::bound_t              high_i,
  output sabs_pkg::cmp_res_t            res_o,
  output sabs_pkg::bound_t              low_o,
  output sabs_pkg::bound_t              high_o
);
  import sabs_pkg::*;

  bound_t mid_s;

  assign mid_s         = bound_t'(mid_i);
  assign res_o.hit     = (entry_i == key_i);
  assign res_o.greater = (entry_i > key_i);

  // An entry above the key pulls high below the midpoint, otherwise low moves up.
  assign low_o  = res_o.greater ? low_i : (mid_s + bound_t'(1));
  assign high_o = res_o.greater ? (mid_s - bound_t'(1)) : high_i;

endmodule

### hw/rtl/sorted_array_binary_search.sv
// Sequence: a load writes one entry and gives no result. A search with P probes (at most
// floor(log2(n)) + 1 for a range of n entries) visits S_READ and S_CMP once per probe and
// then S_DONE, plus a last S_READ on a miss; a bad range goes from S_IDLE to S_DONE.
// Each probe costs one registered memory read plus one pass through the compare unit.
// Throughput: one search at a time; in_tready is low until the result is registered.
// Reset clears the sequencer and output valid; array contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_array_binary_search: binary search over a stored sorted array
// Load requests write one array entry. Search requests narrow an inclusive
// index range by midpoint probes and report found, not found or bad range.
// ----------------------------------------------------------------------------
module sorted_array_binary_search #(
  parameter int DEPTH      = sabs_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = sabs_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // write_index, write_value, search_value, range_low, range_high (low bit up)
  input  logic [sabs_pkg::IN_TDATA_W-1:0]    in_tdata,
  // opcode
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status, found_index (low bit up)
  output logic [sabs_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import sabs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DONE
  } state_t;

  // Input fields.
  logic        [IDX_BITS-1:0]   in_write_index;
  logic signed [FIELD_BITS-1:0] in_write_value;
  logic signed [FIELD_BITS-1:0] in_search_value;
  logic        [IDX_BITS-1:0]   in_range_low;
  logic        [IDX_BITS-1:0]   in_range_high;
  opcode_t                      in_opcode;

  assign in_write_index  = in_tdata[9:0];
  assign in_write_value  = in_tdata[41:10];
  assign in_search_value = in_tdata[73:42];
  assign in_range_low    = in_tdata[83:74];
  assign in_range_high   = in_tdata[93:84];
  assign in_opcode       = opcode_t'(in_tuser[0]);

  state_t                         state_r;
  bound_t                         low_r;
  bound_t                         high_r;
  logic        [IDX_BITS-1:0]     mid_r;
  logic signed [VALUE_BITS-1:0]   key_r;
  logic signed [VALUE_BITS-1:0]   rdata_r;
  status_t                        res_status_r;
  logic        [IDX_BITS-1:0]     res_index_r;
  logic                           out_tvalid_r;
  status_t                        out_status_r;
  logic        [IDX_BITS-1:0]     out_index_r;

  logic signed [VALUE_BITS-1:0]   mem [DEPTH];

  logic                           in_acc;
  logic                           load_ok;
  logic                           bad_range;
  bound_t                         sum_c;
  logic        [IDX_BITS-1:0]     mid_c;
  logic                           range_empty;
  cmp_res_t                       cmp_res;
  bound_t                         low_nxt;
  bound_t                         high_nxt;
  logic                           res_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign load_ok   = (32'(in_write_index) < 32'(DEPTH));
  assign bad_range = (in_range_low > in_range_high) || (32'(in_range_high) >= 32'(DEPTH));

  // Bounds are non-negative whenever a midpoint is used, so the sum shifts right.
  assign sum_c       = low_r + high_r;
  assign mid_c       = sum_c[IDX_BITS:1];
  assign range_empty = (low_r > high_r);

  // A finished result moves to the output register once that register is free.
  assign res_load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  sabs_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .entry_i (rdata_r),
    .key_i   (key_r),
    .mid_i   (mid_r),
    .low_i   (low_r),
    .high_i  (high_r),
    .res_o   (cmp_res),
    .low_o   (low_nxt),
    .high_o  (high_nxt)
  );

  // Array storage: one write port for loads, one registered read for probes.
  always_ff @(posedge clk) begin
    if (in_acc && (in_opcode == OP_LOAD) && load_ok) begin
      mem[AW'(in_write_index)] <= VALUE_BITS'(in_write_value);
    end
    if ((state_r == S_READ) && !range_empty) begin
      rdata_r <= mem[AW'(mid_c)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (res_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_opcode == OP_SEARCH)) begin
            key_r  <= VALUE_BITS'(in_search_value);
            low_r  <= bound_t'(in_range_low);
            high_r <= bound_t'(in_range_high);
            if (bad_range) begin
              res_status_r <= ST_BAD_RANGE;
              res_index_r  <= '0;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          if (range_empty) begin
            res_status_r <= ST_NOT_FOUND;
            res_index_r  <= '0;
            state_r      <= S_DONE;
          end else begin
            mid_r   <= mid_c;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (cmp_res.hit) begin
            res_status_r <= ST_FOUND;
            res_index_r  <= mid_r;
            state_r      <= S_DONE;
          end else begin
            low_r   <= low_nxt;
            high_r  <= high_nxt;
            state_r <= S_READ;
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (res_load) begin
            out_status_r <= res_status_r;
            out_index_r  <= res_index_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_index_r, out_status_r};

  a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ($past(state_r) == S_READ))
    else $error("compare state entered without a preceding array read");

  a_cmp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (low_r <= high_r))
    else $error("probe compared on an empty range");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_status_r != ST_FOUND)) |-> (out_index_r == '0))
    else $error("nonzero index reported without a match");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_DONE))
    else $error("result issued outside the completion state");

endmodule
